FILE: sv/qau_pkg.sv
package qau_pkg;

    localparam int COMP_W = 32;
    localparam int MB_W   = COMP_W + 1;
    localparam int PROD_W = COMP_W + MB_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NCOMP  = 4;
    localparam int NTERM  = 4;

    localparam logic signed [MB_W-1:0] ONE_Q30 = MB_W'(1) <<< 30;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_HAM    = 3'd2,
        ACT_ELEM   = 3'd3,
        ACT_CONJ   = 3'd4,
        ACT_SCL    = 3'd5,
        ACT_VEC    = 3'd6,
        ACT_UNUSED = 3'd7
    } t_action;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] scale;
    } t_request;

    typedef struct packed {
        logic signed [COMP_W-1:0] r_x;
        logic signed [COMP_W-1:0] r_y;
        logic signed [COMP_W-1:0] r_z;
        logic signed [COMP_W-1:0] r_w;
        logic                     saturated;
    } t_result;

endpackage

FILE: sv/qau_reduce.sv
module qau_reduce (
    input  logic signed [qau_pkg::PROD_W-1:0] i_prod [qau_pkg::NTERM],
    input  logic                              i_shift24,
    output logic signed [qau_pkg::COMP_W-1:0] o_value,
    output logic                              o_sat
);
    import qau_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF30 = SUM_W'(1) <<< 29;
    localparam logic signed [SUM_W-1:0] HALF24 = SUM_W'(1) <<< 23;
    localparam logic signed [SUM_W-1:0] MAXV   = SUM_W'(32'h7fff_ffff);
    localparam logic signed [SUM_W-1:0] MINV   = -(SUM_W'(1) <<< (COMP_W - 1));

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] rounded;
    logic signed [SUM_W-1:0] shifted;

    always_comb begin
        sum = '0;
        for (int k = 0; k < NTERM; k++) begin
            sum = sum + SUM_W'(i_prod[k]);
        end
        rounded = sum + (i_shift24 ? HALF24 : HALF30);
        shifted = i_shift24 ? (rounded >>> 24) : (rounded >>> 30);
        o_sat   = 1'b0;
        if (shifted > MAXV) begin
            o_value = MAXV[COMP_W-1:0];
            o_sat   = 1'b1;
        end else if (shifted < MINV) begin
            o_value = MINV[COMP_W-1:0];
            o_sat   = 1'b1;
        end else begin
            o_value = shifted[COMP_W-1:0];
        end
    end

endmodule

FILE: sv/quaternion_arithmetic_unit.sv
// Channel   Direction  Handshake                  Payload
// request   in         i_start high, o_busy low   i_request (qau_pkg::t_request)
// result    out        o_done strobe, one cycle   o_result  (qau_pkg::t_result)
//
// A request is taken in every cycle; o_busy is always low.
// The result strobe is high once the request has passed the input register, the
// sixteen-multiplier product register and the sum, round and saturate register.
// Reset clears only the stage valid flags.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module quaternion_arithmetic_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  qau_pkg::t_request i_request,
    output logic              o_busy,
    output logic              o_done,
    output qau_pkg::t_result  o_result
);
    import qau_pkg::*;

    t_request                  r_req;
    logic                      r_v0;
    logic                      r_v1;
    logic                      r_v2;
    logic signed [PROD_W-1:0]  r_prod [NCOMP][NTERM];
    logic                      r_shift24;
    t_result                   r_result;

    logic signed [COMP_W-1:0]  n_ma [NCOMP][NTERM];
    logic signed [MB_W-1:0]    n_mb [NCOMP][NTERM];
    logic                      n_shift24;
    logic signed [COMP_W-1:0]  qa [NCOMP];
    logic signed [COMP_W-1:0]  qb [NCOMP];
    logic signed [MB_W-1:0]    pb [NCOMP];
    logic signed [MB_W-1:0]    mnb [NCOMP];
    logic signed [COMP_W-1:0]  aw;
    logic signed [COMP_W-1:0]  val [NCOMP];
    logic                      sat [NCOMP];
    t_result                   n_result;

    assign o_busy = 1'b0;

    always_comb begin
        qa[0] = r_req.a_x;
        qa[1] = r_req.a_y;
        qa[2] = r_req.a_z;
        qa[3] = r_req.a_w;
        qb[0] = r_req.b_x;
        qb[1] = r_req.b_y;
        qb[2] = r_req.b_z;
        qb[3] = r_req.b_w;
        for (int j = 0; j < NCOMP; j++) begin
            pb[j]  = MB_W'(qb[j]);
            mnb[j] = -MB_W'(qb[j]);
        end
        aw = (r_req.action == ACT_VEC) ? '0 : r_req.a_w;

        n_shift24 = 1'b0;
        for (int j = 0; j < NCOMP; j++) begin
            for (int k = 0; k < NTERM; k++) begin
                n_ma[j][k] = '0;
                n_mb[j][k] = '0;
            end
        end

        unique case (r_req.action)
            ACT_ADD: begin
                for (int j = 0; j < NCOMP; j++) begin
                    n_ma[j][0] = qa[j];
                    n_mb[j][0] = ONE_Q30;
                    n_ma[j][1] = qb[j];
                    n_mb[j][1] = ONE_Q30;
                end
            end
            ACT_SUB: begin
                for (int j = 0; j < NCOMP; j++) begin
                    n_ma[j][0] = qa[j];
                    n_mb[j][0] = ONE_Q30;
                    n_ma[j][1] = qb[j];
                    n_mb[j][1] = -ONE_Q30;
                end
            end
            ACT_HAM, ACT_VEC: begin
                n_ma[0][0] = aw;    n_mb[0][0] = pb[0];
                n_ma[0][1] = qa[0]; n_mb[0][1] = pb[3];
                n_ma[0][2] = qa[1]; n_mb[0][2] = pb[2];
                n_ma[0][3] = qa[2]; n_mb[0][3] = mnb[1];
                n_ma[1][0] = aw;    n_mb[1][0] = pb[1];
                n_ma[1][1] = qa[1]; n_mb[1][1] = pb[3];
                n_ma[1][2] = qa[2]; n_mb[1][2] = pb[0];
                n_ma[1][3] = qa[0]; n_mb[1][3] = mnb[2];
                n_ma[2][0] = aw;    n_mb[2][0] = pb[2];
                n_ma[2][1] = qa[2]; n_mb[2][1] = pb[3];
                n_ma[2][2] = qa[0]; n_mb[2][2] = pb[1];
                n_ma[2][3] = qa[1]; n_mb[2][3] = mnb[0];
                n_ma[3][0] = aw;    n_mb[3][0] = pb[3];
                n_ma[3][1] = qa[0]; n_mb[3][1] = mnb[0];
                n_ma[3][2] = qa[1]; n_mb[3][2] = mnb[1];
                n_ma[3][3] = qa[2]; n_mb[3][3] = mnb[2];
            end
            ACT_ELEM: begin
                for (int j = 0; j < NCOMP; j++) begin
                    n_ma[j][0] = qa[j];
                    n_mb[j][0] = pb[j];
                end
            end
            ACT_CONJ: begin
                for (int j = 0; j < NCOMP; j++) begin
                    n_ma[j][0] = qa[j];
                    n_mb[j][0] = (j == NCOMP - 1) ? ONE_Q30 : -ONE_Q30;
                end
            end
            ACT_SCL: begin
                n_shift24 = 1'b1;
                for (int j = 0; j < NCOMP; j++) begin
                    n_ma[j][0] = r_req.scale;
                    n_mb[j][0] = pb[j];
                end
            end
            default: begin
                n_shift24 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_request;
        end
        r_shift24 <= n_shift24;
        for (int j = 0; j < NCOMP; j++) begin
            for (int k = 0; k < NTERM; k++) begin
                r_prod[j][k] <= PROD_W'(n_ma[j][k]) * PROD_W'(n_mb[j][k]);
            end
        end
        r_result <= n_result;
    end

    for (genvar g = 0; g < NCOMP; g++) begin : g_lane
        qau_reduce u_reduce (
            .i_prod    (r_prod[g]),
            .i_shift24 (r_shift24),
            .o_value   (val[g]),
            .o_sat     (sat[g])
        );
    end

    always_comb begin
        n_result.r_x       = val[0];
        n_result.r_y       = val[1];
        n_result.r_z       = val[2];
        n_result.r_w       = val[3];
        n_result.saturated = sat[0] | sat[1] | sat[2] | sat[3];
    end

    assign o_done   = r_v2;
    assign o_result = r_result;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 o_done)
        else $error("A request did not produce a result three cycles later.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 3))
        else $error("A result appeared without a matching request.");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturated) |->
            (o_result.r_x == 32'sh7fff_ffff || o_result.r_x == 32'sh8000_0000 ||
             o_result.r_y == 32'sh7fff_ffff || o_result.r_y == 32'sh8000_0000 ||
             o_result.r_z == 32'sh7fff_ffff || o_result.r_z == 32'sh8000_0000 ||
             o_result.r_w == 32'sh7fff_ffff || o_result.r_w == 32'sh8000_0000))
        else $error("Saturation flagged but no component is at a limit.");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && r_req.action == ACT_UNUSED) |->
            ##2 (o_done && o_result == '0))
        else $error("An unused action code did not give an all-zero result.");

endmodule

FILE: sim/tb_quaternion_arithmetic_unit.sv
module tb_quaternion_arithmetic_unit;
    import qau_pkg::*;

    typedef logic signed [71:0] t_wide;

    localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE      = 32'sh4000_0000;
    localparam logic signed [31:0] Q_TIE      = 32'sh2000_0000;
    localparam logic signed [31:0] S_ONE      = 32'sh0100_0000;
    localparam logic signed [31:0] S_TIE      = 32'sh0080_0000;
    localparam int unsigned        RAND_ITEMS = 300;
    localparam int unsigned        STALL_LIMIT = 2000;
    localparam int unsigned        DRAIN_CYCLES = 6;

    class quat_scoreboard;
        t_result     expected_results[$];
        int unsigned mismatches;
        int unsigned compared;
        int unsigned clipped;

        function logic signed [31:0] saturate(t_wide v, inout bit sat);
            if (v > 72'sd2147483647) begin
                sat = 1'b1;
                return Q_MAX;
            end
            if (v < -72'sd2147483648) begin
                sat = 1'b1;
                return Q_MIN;
            end
            return v[31:0];
        endfunction

        // Round to nearest with ties towards plus infinity, then clip.
        function logic signed [31:0] round_sat(t_wide acc, int unsigned frac, inout bit sat);
            t_wide biased;
            biased = acc + (t_wide'(1) <<< (frac - 1));
            return saturate(biased >>> frac, sat);
        endfunction

        function t_result quat_expected(t_request q);
            t_wide              a[4];
            t_wide              b[4];
            t_wide              sc;
            t_wide              aw;
            logic signed [31:0] c[4];
            bit                 sat;
            t_result            r;
            a[0] = t_wide'($signed(q.a_x));
            a[1] = t_wide'($signed(q.a_y));
            a[2] = t_wide'($signed(q.a_z));
            a[3] = t_wide'($signed(q.a_w));
            b[0] = t_wide'($signed(q.b_x));
            b[1] = t_wide'($signed(q.b_y));
            b[2] = t_wide'($signed(q.b_z));
            b[3] = t_wide'($signed(q.b_w));
            sc   = t_wide'($signed(q.scale));
            aw   = (q.action == ACT_VEC) ? t_wide'(0) : a[3];
            sat  = 1'b0;
            for (int i = 0; i < 4; i++) c[i] = '0;
            case (q.action)
                ACT_ADD: begin
                    for (int i = 0; i < 4; i++) c[i] = saturate(a[i] + b[i], sat);
                end
                ACT_SUB: begin
                    for (int i = 0; i < 4; i++) c[i] = saturate(a[i] - b[i], sat);
                end
                ACT_HAM, ACT_VEC: begin
                    c[0] = round_sat(aw * b[0] + a[0] * b[3] + a[1] * b[2] - a[2] * b[1],
                                     30, sat);
                    c[1] = round_sat(aw * b[1] + a[1] * b[3] + a[2] * b[0] - a[0] * b[2],
                                     30, sat);
                    c[2] = round_sat(aw * b[2] + a[2] * b[3] + a[0] * b[1] - a[1] * b[0],
                                     30, sat);
                    c[3] = round_sat(aw * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2],
                                     30, sat);
                end
                ACT_ELEM: begin
                    for (int i = 0; i < 4; i++) c[i] = round_sat(a[i] * b[i], 30, sat);
                end
                ACT_CONJ: begin
                    for (int i = 0; i < 3; i++) c[i] = saturate(-a[i], sat);
                    c[3] = a[3][31:0];
                end
                ACT_SCL: begin
                    for (int i = 0; i < 4; i++) c[i] = round_sat(sc * b[i], 24, sat);
                end
                default: begin
                end
            endcase
            r.r_x       = c[0];
            r.r_y       = c[1];
            r.r_z       = c[2];
            r.r_w       = c[3];
            r.saturated = sat;
            return r;
        endfunction

        function void note_request(t_request q);
            expected_results.push_back(quat_expected(q));
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %h arrived with none outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            compared++;
            if (want.saturated) clipped++;
            if (got.r_x !== want.r_x)
                report_mismatch($sformatf("r_x got %h expected %h", got.r_x, want.r_x));
            if (got.r_y !== want.r_y)
                report_mismatch($sformatf("r_y got %h expected %h", got.r_y, want.r_y));
            if (got.r_z !== want.r_z)
                report_mismatch($sformatf("r_z got %h expected %h", got.r_z, want.r_z));
            if (got.r_w !== want.r_w)
                report_mismatch($sformatf("r_w got %h expected %h", got.r_w, want.r_w));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated got %b expected %b",
                                          got.saturated, want.saturated));
        endtask
    endclass

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     i_start   = 1'b0;
    t_request i_request = '0;
    logic     o_busy;
    logic     o_done;
    t_result  o_result;

    quat_scoreboard sb = new();
    int unsigned    action_count[8];
    int unsigned    stall_cycles = 0;
    int unsigned    phase_idle[4] = '{0, 65, 0, 37};

    quaternion_arithmetic_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_request(i_request),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timed out with %0d results outstanding.", sb.expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_q30();
        case ($urandom_range(7))
            0, 1, 2: return $urandom();
            3: begin
                case ($urandom_range(5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    4: return -Q_ONE;
                    default: return 32'sd1;
                endcase
            end
            default: return $signed($urandom()) >>> $urandom_range(1, 3);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_scale();
        if ($urandom_range(2) == 0) return $urandom();
        return $signed($urandom()) >>> $urandom_range(1, 7);
    endfunction

    function automatic t_request rand_request();
        t_request q;
        q.action = 3'($urandom_range(7));
        q.a_x    = rand_q30();
        q.a_y    = rand_q30();
        q.a_z    = rand_q30();
        q.a_w    = rand_q30();
        q.b_x    = rand_q30();
        q.b_y    = rand_q30();
        q.b_z    = rand_q30();
        q.b_w    = rand_q30();
        q.scale  = rand_scale();
        return q;
    endfunction

    function automatic t_request uniform_request(logic [2:0] act, logic signed [31:0] av,
                                                 logic signed [31:0] bv, logic signed [31:0] sc);
        t_request q;
        q.action = act;
        q.a_x    = av;
        q.a_y    = av;
        q.a_z    = av;
        q.a_w    = av;
        q.b_x    = bv;
        q.b_y    = bv;
        q.b_z    = bv;
        q.b_w    = bv;
        q.scale  = sc;
        return q;
    endfunction

    task automatic send_request(t_request q, int unsigned idle_pct);
        i_start   <= 1'b1;
        i_request <= q;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(q);
        action_count[q.action]++;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    initial begin
        t_request q;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(uniform_request(ACT_ADD, '0, '0, '0), 0);
        send_request(uniform_request(ACT_ADD, Q_MAX, Q_MAX, Q_MAX), 0);
        send_request(uniform_request(ACT_ADD, Q_MIN, Q_MIN, Q_MIN), 0);
        send_request(uniform_request(ACT_SUB, Q_MIN, Q_MAX, '0), 0);
        send_request(uniform_request(ACT_SUB, Q_MAX, Q_MIN, '0), 0);
        q = rand_request();
        q.action = ACT_HAM;
        q.a_x = '0;
        q.a_y = '0;
        q.a_z = '0;
        q.a_w = Q_ONE;
        send_request(q, 0);
        send_request(uniform_request(ACT_HAM, Q_MIN, Q_MIN, Q_MAX), 0);
        send_request(uniform_request(ACT_HAM, Q_MAX, Q_MAX, Q_MIN), 0);
        send_request(uniform_request(ACT_ELEM, Q_MIN, Q_MIN, '0), 0);
        // Products lying exactly halfway between two codes round upwards.
        send_request(uniform_request(ACT_ELEM, 32'sd1, Q_TIE, '0), 0);
        send_request(uniform_request(ACT_ELEM, -32'sd1, Q_TIE, '0), 0);
        send_request(uniform_request(ACT_CONJ, Q_MIN, Q_MAX, Q_MAX), 0);
        send_request(uniform_request(ACT_CONJ, Q_MAX, Q_MIN, Q_MIN), 0);
        send_request(uniform_request(ACT_SCL, Q_MAX, Q_MAX, Q_MAX), 0);
        send_request(uniform_request(ACT_SCL, Q_MIN, Q_MIN, Q_MIN), 0);
        send_request(uniform_request(ACT_SCL, Q_MAX, S_TIE, 32'sd1), 0);
        send_request(uniform_request(ACT_SCL, Q_MIN, -S_TIE, 32'sd1), 0);
        q = rand_request();
        q.action = ACT_SCL;
        q.scale  = S_ONE;
        send_request(q, 0);
        q = rand_request();
        q.action = ACT_VEC;
        send_request(q, 0);
        send_request(uniform_request(ACT_VEC, Q_MIN, Q_MIN, Q_MAX), 0);
        send_request(uniform_request(ACT_UNUSED, Q_MAX, Q_MIN, Q_MAX), 0);
        send_request(rand_request() | {ACT_UNUSED, {9 * 32{1'b0}}}, 0);

        foreach (phase_idle[p]) begin
            repeat (RAND_ITEMS) send_request(rand_request(), phase_idle[p]);
        end
        i_start <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Compared %0d results over all eight action codes, %0d of them clipped.",
                 sb.compared, sb.clipped);
        $display("Requests per action: %0d %0d %0d %0d %0d %0d %0d %0d.",
                 action_count[0], action_count[1], action_count[2], action_count[3],
                 action_count[4], action_count[5], action_count[6], action_count[7]);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/qau_pkg.sv
sv/qau_reduce.sv
sv/quaternion_arithmetic_unit.sv
sim/tb_quaternion_arithmetic_unit.sv
